// File: rtl/rc4sc_pkg.sv
// Package for the RC4 stream cipher: constants, control word types and the microcode table.
`default_nettype none
package rc4sc_pkg;

  localparam int BYTE_W      = 8;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int KEY_IDX_W   = 3;
  localparam int TABLE_DEPTH = 256;
  localparam int STEP_W      = 4;

  localparam logic [BYTE_W-1:0]    TABLE_LAST = BYTE_W'(TABLE_DEPTH - 1);
  localparam logic [KEY_IDX_W-1:0] KEY_LAST   = KEY_IDX_W'(KEY_BYTES - 1);

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses.
  localparam step_t ST_IDLE    = 4'd0;
  localparam step_t ST_KS0     = 4'd1;
  localparam step_t ST_KS1     = 4'd2;
  localparam step_t ST_KS2     = 4'd3;
  localparam step_t ST_KS3     = 4'd4;
  localparam step_t ST_KS4     = 4'd5;
  localparam step_t ST_KS5     = 4'd6;
  localparam step_t ST_KS6     = 4'd7;
  localparam step_t ST_KS7     = 4'd8;
  localparam step_t ST_FILL    = 4'd9;
  localparam step_t ST_SCH0    = 4'd10;
  localparam step_t ST_SCH1    = 4'd11;
  localparam step_t ST_SCH2    = 4'd12;
  localparam step_t ST_SCH3    = 4'd13;
  localparam step_t ST_SCH4    = 4'd14;
  localparam step_t ST_SCH_END = 4'd15;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_CLR} cnt_op_t;
  typedef enum logic [1:0] {J_HOLD, J_CLR, J_SCHED, J_KS} j_op_t;
  typedef enum logic [1:0] {RA_CNT, RA_J, RA_SUM} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_FILL, WR_CNT_RD, WR_J_A} wr_op_t;
  typedef enum logic [2:0] {
    JMP_NEXT, JMP_ALWAYS, JMP_WAIT_IN, JMP_CNT_MORE, JMP_OUT_FREE
  } jump_t;

  typedef struct packed {
    cnt_op_t cnt_op;
    j_op_t   j_op;
    rd_sel_t rd_sel;
    wr_op_t  wr_op;
    logic    ld_a;
    logic    ld_b;
    logic    key_step;
    logic    set_done;
    logic    ld_out;
    jump_t   jump;
    step_t   target;
  } uword_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    cnt_op_t cnt_op;
    j_op_t   j_op;
    rd_sel_t rd_sel;
    wr_op_t  wr_op;
    logic    ld_a;
    logic    ld_b;
    logic    key_step;
    logic    ld_in;
    logic    sched_start;
    logic    ld_out;
  } dp_ctrl_t;

  typedef struct packed {
    logic cnt_last;
  } dp_status_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.jump   = JMP_WAIT_IN;
        w.target = ST_FILL;
      end
      ST_KS0: begin
        w.cnt_op = CNT_INC;
      end
      ST_KS1: begin
        w.rd_sel = RA_CNT;
      end
      ST_KS2: begin
        w.ld_a = 1'b1;
        w.j_op = J_KS;
      end
      ST_KS3: begin
        w.rd_sel = RA_J;
      end
      ST_KS4: begin
        w.ld_b  = 1'b1;
        w.wr_op = WR_CNT_RD;
      end
      ST_KS5: begin
        w.wr_op = WR_J_A;
      end
      ST_KS6: begin
        w.rd_sel = RA_SUM;
      end
      ST_KS7: begin
        // Keep reading the keystream entry so that it survives a stalled output.
        w.rd_sel = RA_SUM;
        w.ld_out = 1'b1;
        w.jump   = JMP_OUT_FREE;
        w.target = ST_IDLE;
      end
      ST_FILL: begin
        w.wr_op  = WR_FILL;
        w.cnt_op = CNT_INC;
        w.jump   = JMP_CNT_MORE;
        w.target = ST_FILL;
      end
      ST_SCH0: begin
        w.rd_sel = RA_CNT;
      end
      ST_SCH1: begin
        w.ld_a = 1'b1;
        w.j_op = J_SCHED;
      end
      ST_SCH2: begin
        w.rd_sel = RA_J;
      end
      ST_SCH3: begin
        w.wr_op = WR_CNT_RD;
      end
      ST_SCH4: begin
        w.wr_op    = WR_J_A;
        w.cnt_op   = CNT_INC;
        w.key_step = 1'b1;
        w.jump     = JMP_CNT_MORE;
        w.target   = ST_SCH0;
      end
      ST_SCH_END: begin
        w.j_op     = J_CLR;
        w.cnt_op   = CNT_CLR;
        w.set_done = 1'b1;
        w.jump     = JMP_ALWAYS;
        w.target   = ST_KS0;
      end
      default: begin
        w.jump   = JMP_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rc4sc_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none
module rc4sc_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_start,
  input  logic                   out_busy,
  input  rc4sc_pkg::dp_status_t  status,
  output logic                   in_ready,
  output rc4sc_pkg::dp_ctrl_t    ctrl
);

  rc4sc_pkg::step_t  step;
  rc4sc_pkg::step_t  step_next;
  logic              done;
  logic              done_next;
  rc4sc_pkg::uword_t uword;
  logic              accept;
  logic              need_sched;

  assign uword      = rc4sc_pkg::ucode_rom(step);
  assign in_ready   = (uword.jump == rc4sc_pkg::JMP_WAIT_IN);
  assign accept     = in_valid && in_ready;
  // The permutation is never read before a first schedule has filled it.
  assign need_sched = in_start || !done;

  always_comb begin
    case (uword.jump)
      rc4sc_pkg::JMP_NEXT:     step_next = rc4sc_pkg::step_t'(step + 1'b1);
      rc4sc_pkg::JMP_ALWAYS:   step_next = uword.target;
      rc4sc_pkg::JMP_WAIT_IN: begin
        if (!accept) begin
          step_next = step;
        end else if (need_sched) begin
          step_next = uword.target;
        end else begin
          step_next = rc4sc_pkg::step_t'(step + 1'b1);
        end
      end
      rc4sc_pkg::JMP_CNT_MORE: begin
        step_next = status.cnt_last ? rc4sc_pkg::step_t'(step + 1'b1) : uword.target;
      end
      rc4sc_pkg::JMP_OUT_FREE: step_next = out_busy ? step : uword.target;
      default:                 step_next = rc4sc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    done_next        = done | uword.set_done;
    ctrl.cnt_op      = uword.cnt_op;
    ctrl.j_op        = uword.j_op;
    ctrl.rd_sel      = uword.rd_sel;
    ctrl.wr_op       = uword.wr_op;
    ctrl.ld_a        = uword.ld_a;
    ctrl.ld_b        = uword.ld_b;
    ctrl.key_step    = uword.key_step;
    ctrl.ld_in       = accept;
    ctrl.sched_start = accept && need_sched;
    ctrl.ld_out      = uword.ld_out && !out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= rc4sc_pkg::ST_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= done_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rc4sc_datapath.sv
// Datapath: permutation memory, indices, key register, operand and output registers.
`default_nettype none
module rc4sc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  rc4sc_pkg::dp_ctrl_t                ctrl,
  input  logic                               cfg_wr_en,
  input  logic [rc4sc_pkg::KEY_W-1:0]        cfg_wr_data,
  input  logic [rc4sc_pkg::BYTE_W-1:0]       in_byte,
  input  logic                               out_taken,
  output rc4sc_pkg::dp_status_t              status,
  output logic                               out_valid,
  output logic [rc4sc_pkg::BYTE_W-1:0]       out_byte,
  output logic [rc4sc_pkg::BYTE_W-1:0]       keystream_byte
);

  logic [rc4sc_pkg::BYTE_W-1:0]    mem [rc4sc_pkg::TABLE_DEPTH];
  logic [rc4sc_pkg::BYTE_W-1:0]    rdata;
  logic [rc4sc_pkg::BYTE_W-1:0]    raddr;
  logic [rc4sc_pkg::BYTE_W-1:0]    waddr;
  logic [rc4sc_pkg::BYTE_W-1:0]    wdata;
  logic                            wr_en;
  logic [rc4sc_pkg::BYTE_W-1:0]    cnt;
  logic [rc4sc_pkg::BYTE_W-1:0]    cnt_next;
  logic [rc4sc_pkg::BYTE_W-1:0]    jreg;
  logic [rc4sc_pkg::BYTE_W-1:0]    jreg_next;
  logic [rc4sc_pkg::KEY_IDX_W-1:0] kidx;
  logic [rc4sc_pkg::KEY_IDX_W-1:0] kidx_next;
  logic [rc4sc_pkg::KEY_W-1:0]     cipher_key;
  logic [rc4sc_pkg::BYTE_W-1:0]    key_byte;
  logic [rc4sc_pkg::BYTE_W-1:0]    a_val;
  logic [rc4sc_pkg::BYTE_W-1:0]    b_val;
  logic [rc4sc_pkg::BYTE_W-1:0]    in_data;

  assign key_byte        = cipher_key[kidx*rc4sc_pkg::BYTE_W +: rc4sc_pkg::BYTE_W];
  assign status.cnt_last = (cnt == rc4sc_pkg::TABLE_LAST);

  always_comb begin
    case (ctrl.rd_sel)
      rc4sc_pkg::RA_CNT: raddr = cnt;
      rc4sc_pkg::RA_J:   raddr = jreg;
      rc4sc_pkg::RA_SUM: raddr = a_val + b_val;
      default:           raddr = cnt;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    case (ctrl.wr_op)
      rc4sc_pkg::WR_FILL: begin
        waddr = cnt;
        wdata = cnt;
      end
      rc4sc_pkg::WR_CNT_RD: begin
        waddr = cnt;
        wdata = rdata;
      end
      rc4sc_pkg::WR_J_A: begin
        waddr = jreg;
        wdata = a_val;
      end
      default: begin
        wr_en = 1'b0;
        waddr = cnt;
        wdata = rdata;
      end
    endcase
  end

  always_comb begin
    if (ctrl.sched_start) begin
      cnt_next = '0;
    end else begin
      case (ctrl.cnt_op)
        rc4sc_pkg::CNT_INC: cnt_next = cnt + 1'b1;
        rc4sc_pkg::CNT_CLR: cnt_next = '0;
        default:            cnt_next = cnt;
      endcase
    end
  end

  always_comb begin
    if (ctrl.sched_start) begin
      jreg_next = '0;
    end else begin
      case (ctrl.j_op)
        rc4sc_pkg::J_CLR:   jreg_next = '0;
        rc4sc_pkg::J_SCHED: jreg_next = jreg + rdata + key_byte;
        rc4sc_pkg::J_KS:    jreg_next = jreg + rdata;
        default:            jreg_next = jreg;
      endcase
    end
  end

  // The key byte index runs cyclically over the bytes that the schedule uses.
  always_comb begin
    if (ctrl.sched_start) begin
      kidx_next = '0;
    end else if (ctrl.key_step) begin
      kidx_next = (kidx == rc4sc_pkg::KEY_LAST) ? '0 : kidx + 1'b1;
    end else begin
      kidx_next = kidx;
    end
  end

  // Read data is registered; a write and a read in the same cycle return the old entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      jreg       <= '0;
      kidx       <= '0;
      cipher_key <= '0;
      out_valid  <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      jreg <= jreg_next;
      kidx <= kidx_next;
      if (cfg_wr_en) begin
        cipher_key <= cfg_wr_data;
      end
      if (ctrl.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_a) begin
      a_val <= rdata;
    end
    if (ctrl.ld_b) begin
      b_val <= rdata;
    end
    if (ctrl.ld_in) begin
      in_data <= in_byte;
    end
    if (ctrl.ld_out) begin
      out_byte       <= in_data ^ rdata;
      keystream_byte <= rdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rc4_stream_cipher_top.sv
// Top level of the RC4 stream cipher with stream ports and a key register.
// RC4 cipher on a byte stream. Each input word carries one byte and a start flag in tuser;
// the block returns that byte XORed with the next keystream byte, together with the
// keystream byte itself. The 64-bit key is written through cfg_wr_en/cfg_wr_data; the
// user is to write it only while the block is idle, which the block does not enforce, and
// it takes effect at the next key schedule. A word with the start flag set, and the first
// word after reset, first runs the key schedule: it fills the permutation memory, then
// runs its 256 swap steps and a closing step. A keystream step then makes three dependent
// reads and two writes of the permutation memory, which has one registered read port and
// one write port. Input is refused while a word is being worked on; a finished result
// waits in the output register while the next input word is taken in, and that next word
// holds in its last cycle until the output register is free.
`default_nettype none
module rc4_stream_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tuser,   // start_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // out_byte [7:0], keystream_byte [15:8]
);

  rc4sc_pkg::dp_ctrl_t          ctrl;
  rc4sc_pkg::dp_status_t        status;
  logic                         out_busy;
  logic [rc4sc_pkg::BYTE_W-1:0] out_byte;
  logic [rc4sc_pkg::BYTE_W-1:0] keystream_byte;

  assign out_busy     = m_axis_tvalid && !m_axis_tready;
  assign m_axis_tdata = {keystream_byte, out_byte};

  rc4sc_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_start (s_axis_tuser),
    .out_busy (out_busy),
    .status   (status),
    .in_ready (s_axis_tready),
    .ctrl     (ctrl)
  );

  rc4sc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_byte        (s_axis_tdata),
    .out_taken      (m_axis_tready),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_byte       (out_byte),
    .keystream_byte (keystream_byte)
  );

endmodule
`default_nettype wire

// File: rtl/rc4sc_checker.sv
// Port-level checker for the RC4 stream cipher and its bind to the top level.
`default_nettype none
module rc4sc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Once a word is taken in, no second word is taken until its work is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  // A new result appears exactly when the block returns to waiting for input.
  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result produced without returning to idle");

endmodule

bind rc4_stream_cipher_top rc4sc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: bench/tb_rc4_stream_cipher_top.sv
// Self-checking testbench for the RC4 stream cipher top level.
`timescale 1ns / 100ps

module tb_rc4_stream_cipher_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int QUIET_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_WORDS    = 408;

  // Tracks the cipher state and checks each returned byte pair in order.
  class rc4_scoreboard;
    bit [7:0]  perm [rc4sc_pkg::TABLE_DEPTH];
    bit [7:0]  idx_i;
    bit [7:0]  idx_j;
    bit        sched_valid;
    bit [63:0] cipher_key;
    bit [15:0] pending_cipher [$];
    int        errors;

    function void run_key_schedule();
      bit [7:0] acc;
      bit [7:0] tmp;
      acc = 8'd0;
      for (int n = 0; n < rc4sc_pkg::TABLE_DEPTH; n++) perm[n] = 8'(n);
      for (int n = 0; n < rc4sc_pkg::TABLE_DEPTH; n++) begin
        acc = acc + perm[n] + cipher_key[8 * (n % rc4sc_pkg::KEY_BYTES) +: 8];
        tmp = perm[n];
        perm[n] = perm[acc];
        perm[acc] = tmp;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
      sched_valid = 1'b1;
    endfunction

    function void note_word(bit som, bit [7:0] data);
      bit [7:0] tmp;
      bit [7:0] ks;
      if (som || !sched_valid) run_key_schedule();
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      tmp = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = tmp;
      ks = perm[8'(perm[idx_i] + perm[idx_j])];
      pending_cipher.push_back({ks, data ^ ks});
    endfunction

    function void check_word(bit [15:0] word);
      bit [15:0] want;
      if (pending_cipher.size() == 0) begin
        $display("%0t: unexpected output word %04h", $time, word);
        errors++;
        return;
      end
      want = pending_cipher.pop_front();
      if (word[7:0] !== want[7:0]) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want[7:0], word[7:0]);
        errors++;
      end
      if (word[15:8] !== want[15:8]) begin
        $display("%0t: keystream_byte expected %02h actual %02h", $time, want[15:8],
                 word[15:8]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [63:0] cfg_wr_data   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // in_byte
  logic        s_axis_tuser  = 1'b0; // start_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // out_byte [7:0], keystream_byte [15:8]

  rc4_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  bit hold_req     = 1'b0;
  int words_sent   = 0;
  int quiet_count  = 0;

  rc4_stream_cipher_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: check accepted words, then pick tready for the next cycle.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("rc4_stream_cipher_top test failed");
        $finish;
      end
    end
  end

  task automatic send_word(input bit som, input bit [7:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= som;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_word(som, data);
    words_sent++;
  endtask

  // Waits until every expected word is back and the block has settled.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cipher.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input bit [63:0] k);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.cipher_key = k;
  endtask

  task automatic send_message(input int len, input bit fresh);
    for (int k = 0; k < len; k++) send_word(fresh && (k == 0), 8'($urandom_range(255)));
  endtask

  function automatic bit [63:0] pick_key();
    case ($urandom_range(5))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'($urandom_range(255)) << (8 * $urandom_range(7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first word after reset runs the schedule with the reset key even without start.
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h01);
    send_word(1'b0, 8'h80);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'hAA);
    send_word(1'b0, 8'h55);
    // A new key must leave the running keystream alone until the next start.
    write_key('1);
    send_word(1'b0, 8'h0F);
    send_word(1'b0, 8'hF0);
    send_word(1'b0, 8'h3C);
    send_word(1'b1, 8'h00);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'hC3);
    write_key(64'h0807060504030201);
    send_word(1'b0, 8'h7E);
    send_word(1'b1, 8'h81);
    send_word(1'b0, 8'h18);
    write_key(64'd0);
    send_word(1'b1, 8'hE7);
    send_word(1'b0, 8'h42);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      endcase
      write_key(pick_key());
      words_sent = 0;
      if (phase == 0) begin
        // Long enough for the i index to wrap; the output side holds off at its start.
        hold_req = 1'b1;
        send_message(300, 1'b1);
      end
      while (words_sent < PHASE_WORDS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        if (len > PHASE_WORDS - words_sent) len = PHASE_WORDS - words_sent;
        // Now and then a message carries on without a start flag.
        send_message(len, $urandom_range(7) != 0);
        if ($urandom_range(5) == 0) write_key(pick_key());
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_cipher.size() == 0) begin
      $display("rc4_stream_cipher_top test passed");
    end else begin
      $display("rc4_stream_cipher_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rc4sc_pkg.sv
rtl/rc4sc_sequencer.sv
rtl/rc4sc_datapath.sv
rtl/rc4_stream_cipher_top.sv
rtl/rc4sc_checker.sv
bench/tb_rc4_stream_cipher_top.sv
